// ----- src/pbse_pkg.sv -----
// pbse_pkg: shared types and codes for the prefix boolean shape evaluator
// no dependencies; used by pbse_seq and prefix_boolean_shape_evaluator
`timescale 1ns / 1ps

package pbse_pkg;

  localparam int unsigned ProgDepth  = 256;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned ShapeCount = 64;

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // operation codes; the two unused codes fold like union
  localparam logic [2:0] OP_LEAF     = 3'd0;
  localparam logic [2:0] OP_MERGE    = 3'd1;
  localparam logic [2:0] OP_INTERSEC = 3'd2;
  localparam logic [2:0] OP_SYMDIFF  = 3'd3;
  localparam logic [2:0] OP_DIFF     = 3'd4;
  localparam logic [2:0] OP_BACKDIFF = 3'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_OVERRUN  = 2'd2
  } pbse_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DECODE,
    S_FOLD,
    S_DONE
  } pbse_state_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  word_address;
    logic [2:0]  opcode;
    logic        invert_flag;
    logic [7:0]  argument;
    logic [63:0] shape_states;
  } pbse_in_t;

  typedef struct packed {
    logic         verdict;
    pbse_status_e status;
  } pbse_out_t;

  // one program word as stored
  typedef struct packed {
    logic [2:0] opcode;
    logic       invert_flag;
    logic [7:0] argument;
  } pbse_word_t;

  // request handed from the front end to the sequencer
  typedef struct packed {
    logic        evaluate;
    logic [63:0] shape_states;
  } pbse_start_t;

  // pending operation on the stack
  typedef struct packed {
    logic [2:0] opcode;
    logic       invert_flag;
    logic [7:0] remaining;
    logic       acc;
    logic       started;
  } pbse_entry_t;

endpackage

// ----- src/pbse_ram.sv -----
// pbse_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pbse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pbse_seq.sv -----
// pbse_seq: program walker; fetches words, keeps the pending stack in a ram
// depends on pbse_pkg and pbse_ram
`timescale 1ns / 1ps

module pbse_seq #(
  parameter int unsigned PROG_DEPTH  = pbse_pkg::ProgDepth,
  parameter int unsigned STACK_DEPTH = pbse_pkg::StackDepth,
  parameter int unsigned SHAPE_COUNT = pbse_pkg::ShapeCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_valid_i,
  output logic                          start_ready_o,
  input  pbse_pkg::pbse_start_t         start_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output pbse_pkg::pbse_out_t           res_o,
  output logic [$clog2(PROG_DEPTH)-1:0] prog_raddr_o,
  input  logic [11:0]                   prog_rdata_i
);

  localparam int unsigned PW  = $clog2(PROG_DEPTH + 1);
  localparam int unsigned PAW = $clog2(PROG_DEPTH);
  localparam int unsigned LW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned EW  = $bits(pbse_pkg::pbse_entry_t);

  function automatic logic fold_bits(logic [2:0] op, logic a, logic b);
    logic r;
    case (op)
      pbse_pkg::OP_INTERSEC: r = a & b;
      pbse_pkg::OP_SYMDIFF:  r = a ^ b;
      pbse_pkg::OP_DIFF:     r = a & ~b;
      pbse_pkg::OP_BACKDIFF: r = ~a & b;
      default:               r = a | b;
    endcase
    return r;
  endfunction

  pbse_pkg::pbse_state_e state_q, state_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [LW-1:0]         lvl_q, lvl_d;
  logic                  val_q, val_d;
  logic [63:0]           shape_q, shape_d;
  pbse_pkg::pbse_out_t   res_q, res_d;

  logic                  stk_we;
  logic [SAW-1:0]        stk_waddr;
  pbse_pkg::pbse_entry_t stk_wdata;
  logic [SAW-1:0]        stk_raddr;
  logic [EW-1:0]         stk_rdata;

  pbse_pkg::pbse_word_t  word;
  pbse_pkg::pbse_entry_t top_e;
  logic [LW-1:0]         lvl_m1, lvl_m2;
  logic                  leaf_bit, acc_new, pop_val;
  logic [7:0]            rem_new;

  pbse_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign word    = pbse_pkg::pbse_word_t'(prog_rdata_i);
  assign top_e   = pbse_pkg::pbse_entry_t'(stk_rdata);
  assign lvl_m1  = lvl_q - LW'(1);
  assign lvl_m2  = lvl_q - LW'(2);
  assign rem_new = top_e.remaining - 8'd1;

  // shapes beyond the configured count read as outside
  assign leaf_bit = ((32'(word.argument) < 32'(SHAPE_COUNT)) ?
                     shape_q[word.argument[5:0]] : 1'b0) ^ word.invert_flag;
  assign acc_new  = top_e.started ? fold_bits(top_e.opcode, top_e.acc, val_q) : val_q;
  assign pop_val  = acc_new ^ top_e.invert_flag;

  assign prog_raddr_o  = pos_q[PAW-1:0];
  assign start_ready_o = (state_q == pbse_pkg::S_IDLE);
  assign res_valid_o   = (state_q == pbse_pkg::S_DONE);
  assign res_o         = res_q;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    lvl_d     = lvl_q;
    val_d     = val_q;
    shape_d   = shape_q;
    res_d     = res_q;
    stk_we    = 1'b0;
    stk_waddr = lvl_m1[SAW-1:0];
    stk_wdata = top_e;
    stk_raddr = lvl_m1[SAW-1:0];
    case (state_q)
      pbse_pkg::S_IDLE: begin
        if (start_valid_i) begin
          shape_d = start_i.shape_states;
          pos_d   = '0;
          lvl_d   = '0;
          res_d   = '{verdict: 1'b0, status: pbse_pkg::ST_OK};
          state_d = start_i.evaluate ? pbse_pkg::S_FETCH : pbse_pkg::S_DONE;
        end
      end
      pbse_pkg::S_FETCH: begin
        if (pos_q >= PW'(PROG_DEPTH)) begin
          res_d   = '{verdict: 1'b0, status: pbse_pkg::ST_OVERRUN};
          state_d = pbse_pkg::S_DONE;
        end else begin
          pos_d   = pos_q + PW'(1);
          state_d = pbse_pkg::S_DECODE;
        end
      end
      pbse_pkg::S_DECODE: begin
        if (word.opcode != pbse_pkg::OP_LEAF) begin
          if (lvl_q >= LW'(STACK_DEPTH)) begin
            res_d   = '{verdict: 1'b0, status: pbse_pkg::ST_OVERFLOW};
            state_d = pbse_pkg::S_DONE;
          end else begin
            stk_we    = 1'b1;
            stk_waddr = lvl_q[SAW-1:0];
            stk_wdata = '{opcode:      word.opcode,
                          invert_flag: word.invert_flag,
                          remaining:   (word.argument == 8'd0) ? 8'd1 : word.argument,
                          acc:         1'b0,
                          started:     1'b0};
            lvl_d     = lvl_q + LW'(1);
            state_d   = pbse_pkg::S_FETCH;
          end
        end else if (lvl_q == '0) begin
          res_d   = '{verdict: leaf_bit, status: pbse_pkg::ST_OK};
          state_d = pbse_pkg::S_DONE;
        end else begin
          // top entry arrives next cycle
          val_d   = leaf_bit;
          state_d = pbse_pkg::S_FOLD;
        end
      end
      pbse_pkg::S_FOLD: begin
        if (rem_new != 8'd0) begin
          stk_we    = 1'b1;
          stk_wdata = '{opcode:      top_e.opcode,
                        invert_flag: top_e.invert_flag,
                        remaining:   rem_new,
                        acc:         acc_new,
                        started:     1'b1};
          state_d   = pbse_pkg::S_FETCH;
        end else begin
          // operation complete: pop and fold its value into the parent
          val_d = pop_val;
          lvl_d = lvl_m1;
          if (lvl_q == LW'(1)) begin
            res_d   = '{verdict: pop_val, status: pbse_pkg::ST_OK};
            state_d = pbse_pkg::S_DONE;
          end else begin
            stk_raddr = lvl_m2[SAW-1:0];
          end
        end
      end
      pbse_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = pbse_pkg::S_IDLE;
        end
      end
      default: state_d = pbse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbse_pkg::S_IDLE;
      pos_q   <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    shape_q <= shape_d;
    res_q   <= res_d;
  end

`ifndef SYNTHESIS
  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(PROG_DEPTH))
    else $error("program position beyond store");

  a_fold_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pbse_pkg::S_FOLD |-> lvl_q != '0)
    else $error("fold with empty stack");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbse_pkg::S_DONE && res_q.status != pbse_pkg::ST_OK) |-> !res_q.verdict)
    else $error("verdict set on error status");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbse_pkg::S_DONE && !res_ready_i) |=>
      (state_q == pbse_pkg::S_DONE && $stable(res_q)))
    else $error("result dropped before taken");
`endif

endmodule

// ----- src/prefix_boolean_shape_evaluator.sv -----
// prefix_boolean_shape_evaluator: top level with program store and output register
// depends on pbse_pkg, pbse_ram and pbse_seq
//
// usage:
//   one input channel (in_valid_i / in_ready_o / in_data_i) carries write and
//   evaluate requests; one output channel (out_valid_o / out_ready_i /
//   out_data_o) returns exactly one verdict and status per request, in order.
//   a write request stores {opcode, invert_flag, argument} at word_address
//   (ignored past the store end) and answers verdict 0, status ok.
//   an evaluate request walks the program from word 0 in prefix order.
//   an evaluate fetches and decodes each program word in turn (program store
//   read, then decode); each leaf then folds into every stack entry it
//   completes and the one it stops at, one stack entry at a time; the
//   stack ram and program store reads are registered.
//   one request is worked at a time; the next is taken once the sequencer
//   has handed its result to the output register, which may still be waiting.
//   reset clears all control state; the program store is not cleared and
//   must be written before it is evaluated. a stalled receiver holds the
//   output register, then the sequencer, then in_ready_o low.
`timescale 1ns / 1ps

module prefix_boolean_shape_evaluator #(
  parameter int unsigned PROG_DEPTH  = pbse_pkg::ProgDepth,
  parameter int unsigned STACK_DEPTH = pbse_pkg::StackDepth,
  parameter int unsigned SHAPE_COUNT = pbse_pkg::ShapeCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pbse_pkg::pbse_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbse_pkg::pbse_out_t out_data_o
);

  localparam int unsigned PAW = $clog2(PROG_DEPTH);

  logic                  in_acc;
  logic [31:0]           waddr_ext;
  logic                  prog_we;
  logic [PAW-1:0]        prog_raddr;
  logic [11:0]           prog_rdata;
  pbse_pkg::pbse_word_t  prog_wdata;
  pbse_pkg::pbse_start_t start;
  logic                  res_valid, res_ready;
  pbse_pkg::pbse_out_t   res;
  logic                  out_valid_q, out_valid_d;
  pbse_pkg::pbse_out_t   out_data_q;

  assign in_acc     = in_valid_i && in_ready_o;
  assign waddr_ext  = 32'(in_data_i.word_address);
  assign prog_we    = in_acc && (in_data_i.kind == pbse_pkg::KIND_WRITE) &&
                      (waddr_ext < 32'(PROG_DEPTH));
  assign prog_wdata = '{opcode:      in_data_i.opcode,
                        invert_flag: in_data_i.invert_flag,
                        argument:    in_data_i.argument};

  assign start = '{evaluate:     (in_data_i.kind == pbse_pkg::KIND_EVAL),
                   shape_states: in_data_i.shape_states};

  pbse_ram #(
    .WIDTH (12),
    .DEPTH (PROG_DEPTH)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (waddr_ext[PAW-1:0]),
    .wdata_i (prog_wdata),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  pbse_seq #(
    .PROG_DEPTH  (PROG_DEPTH),
    .STACK_DEPTH (STACK_DEPTH),
    .SHAPE_COUNT (SHAPE_COUNT)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_valid_i (in_valid_i),
    .start_ready_o (in_ready_o),
    .start_i       (start),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .prog_raddr_o  (prog_raddr),
    .prog_rdata_i  (prog_rdata)
  );

  // output register frees the sequencer while it is empty or its result is being taken
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- tb/tb_prefix_boolean_shape_evaluator.sv -----
// tb_prefix_boolean_shape_evaluator: self-checking bench for the prefix boolean shape evaluator
// predicts each verdict and status from a mirror of the program store; needs pbse_pkg and the rtl
`timescale 1ns / 1ps

module tb_prefix_boolean_shape_evaluator;
  import pbse_pkg::*;

  // highest spare code; the spare codes fold like union
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  pbse_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  pbse_out_t out_data_o;

  pbse_word_t prog_image [ProgDepth];
  pbse_out_t  expected_results [$];
  pbse_out_t  oldest_result;
  int         fail_count;
  int         requests_sent;
  int         results_seen;
  int         idle_pct;
  int         stall_pct;

  prefix_boolean_shape_evaluator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic fold_bit(input logic [2:0] op, input logic a, input logic b);
    case (op)
      OP_INTERSEC: return a & b;
      OP_SYMDIFF:  return a ^ b;
      OP_DIFF:     return a & ~b;
      OP_BACKDIFF: return ~a & b;
      default:     return a | b;
    endcase
  endfunction

  // walks the mirrored program in prefix order with a bounded pending stack
  function automatic pbse_out_t evaluate_program(input logic [63:0] states);
    pbse_entry_t pending [StackDepth];
    pbse_out_t   res;
    pbse_word_t  w;
    int          level;
    int          pos;
    logic        val;
    logic        done;
    logic        folding;
    res.verdict = 1'b0;
    res.status  = ST_OK;
    level = 0;
    pos   = 0;
    done  = 1'b0;
    while (!done) begin
      if (pos >= ProgDepth) begin
        res.status = ST_OVERRUN;
        done = 1'b1;
      end else begin
        w = prog_image[pos];
        pos++;
        if (w.opcode != OP_LEAF) begin
          if (level >= StackDepth) begin
            res.status = ST_OVERFLOW;
            done = 1'b1;
          end else begin
            pending[level].opcode      = w.opcode;
            pending[level].invert_flag = w.invert_flag;
            pending[level].remaining   = (w.argument == 8'd0) ? 8'd1 : w.argument;
            pending[level].acc         = 1'b0;
            pending[level].started     = 1'b0;
            level++;
          end
        end else begin
          val = (w.argument < ShapeCount) ? states[w.argument] : 1'b0;
          val = val ^ w.invert_flag;
          folding = 1'b1;
          while (folding && level > 0) begin
            if (!pending[level-1].started) begin
              pending[level-1].acc     = val;
              pending[level-1].started = 1'b1;
            end else begin
              pending[level-1].acc = fold_bit(pending[level-1].opcode,
                                              pending[level-1].acc, val);
            end
            pending[level-1].remaining = pending[level-1].remaining - 8'd1;
            if (pending[level-1].remaining != 8'd0) begin
              folding = 1'b0;
            end else begin
              val = pending[level-1].acc ^ pending[level-1].invert_flag;
              level--;
            end
          end
          if (level == 0) begin
            res.verdict = val;
            done = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] random_states();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("error at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // drives one request, holds it until accepted, then records what it must return
  task automatic send_request(input pbse_in_t req);
    pbse_out_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if (req.kind == KIND_WRITE) begin
      prog_image[req.word_address] = {req.opcode, req.invert_flag, req.argument};
      res.verdict = 1'b0;
      res.status  = ST_OK;
    end else begin
      res = evaluate_program(req.shape_states);
    end
    expected_results.push_back(res);
    requests_sent++;
  endtask

  task automatic write_word(input logic [7:0] addr, input logic [2:0] op,
                            input logic inv, input logic [7:0] arg);
    pbse_in_t req;
    req.kind         = KIND_WRITE;
    req.word_address = addr;
    req.opcode       = op;
    req.invert_flag  = inv;
    req.argument     = arg;
    req.shape_states = {$urandom, $urandom};
    send_request(req);
  endtask

  task automatic evaluate(input logic [63:0] states);
    pbse_in_t req;
    req.kind         = KIND_EVAL;
    req.word_address = 8'($urandom);
    req.opcode       = 3'($urandom);
    req.invert_flag  = 1'($urandom);
    req.argument     = 8'($urandom);
    req.shape_states = states;
    send_request(req);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // every word gets written so no evaluation ever reads an undefined word
  task automatic fill_program_store();
    for (int a = 0; a < ProgDepth; a++) begin
      write_word(a[7:0], OP_LEAF, 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_leaf_extremes();
    write_word(8'd0, OP_LEAF, 1'b0, 8'd0);
    evaluate('0);
    evaluate('1);
    write_word(8'd0, OP_LEAF, 1'b1, 8'd63);
    evaluate(64'h8000_0000_0000_0000);
    evaluate(64'h7fff_ffff_ffff_ffff);
    // shape index past the shape count reads as outside
    write_word(8'd0, OP_LEAF, 1'b1, 8'd255);
    evaluate('1);
  endtask

  task automatic test_each_operation();
    logic [63:0] states;
    write_word(8'd1, OP_LEAF, 1'b0, 8'd0);
    write_word(8'd2, OP_LEAF, 1'b0, 8'd1);
    for (int op = OP_MERGE; op <= OP_SPARE7; op++) begin
      write_word(8'd0, op[2:0], op[0], 8'd2);
      states = {$urandom, $urandom};
      states[1:0] = op[1:0];
      evaluate(states);
    end
  endtask

  // a zero operand count behaves as a count of one
  task automatic test_zero_count();
    write_word(8'd0, OP_INTERSEC, 1'b1, 8'd0);
    evaluate(random_states());
  endtask

  // words above 1 are still leaves here, so the inner fold runs off the store end
  task automatic test_program_overrun();
    write_word(8'd0, OP_MERGE, 1'b0, 8'd255);
    write_word(8'd1, OP_SYMDIFF, 1'b1, 8'd255);
    evaluate(random_states());
  endtask

  task automatic test_stack_overflow();
    for (int a = 0; a < StackDepth; a++) begin
      write_word(a[7:0], 3'($urandom_range(OP_MERGE, OP_SPARE7)), 1'($urandom), 8'd1);
    end
    // a full stack that still completes
    write_word(8'(StackDepth), OP_LEAF, 1'($urandom), 8'($urandom_range(63)));
    evaluate(random_states());
    write_word(8'(StackDepth), OP_DIFF, 1'b0, 8'd2);
    evaluate(random_states());
  endtask

  // writes one prefix program from word 0, mostly well formed; some are cut
  // short or nested one level too deep
  task automatic gen_program();
    int         rem [StackDepth+1];
    int         level;
    int         addr;
    int         cap;
    int         cut;
    int         budget;
    int         op_pct;
    int         cnt;
    logic       done;
    logic       folding;
    level  = 0;
    addr   = 0;
    done   = 1'b0;
    cap    = ($urandom_range(11) == 0) ? StackDepth + 1 : StackDepth;
    cut    = ($urandom_range(11) == 0) ? $urandom_range(1, 8) : -1;
    budget = $urandom_range(2, 30);
    op_pct = ($urandom_range(9) == 0) ? 85 : 40;
    while (!done) begin
      if (level < cap && addr < budget && $urandom_range(99) < op_pct) begin
        case ($urandom_range(19))
          0:       cnt = 0;
          1:       cnt = $urandom_range(5, 8);
          default: cnt = $urandom_range(1, 4);
        endcase
        write_word(addr[7:0], 3'($urandom_range(OP_MERGE, OP_SPARE7)), 1'($urandom),
                   cnt[7:0]);
        rem[level] = (cnt == 0) ? 1 : cnt;
        level++;
        if (level > StackDepth) done = 1'b1;
      end else begin
        write_word(addr[7:0], OP_LEAF, 1'($urandom),
                   ($urandom_range(9) == 0) ? 8'($urandom_range(64, 255))
                                            : 8'($urandom_range(63)));
        folding = 1'b1;
        while (folding && level > 0) begin
          rem[level-1]--;
          if (rem[level-1] != 0) folding = 1'b0;
          else level--;
        end
        if (level == 0) done = 1'b1;
      end
      addr++;
      if (addr == cut) done = 1'b1;
    end
  endtask

  task automatic test_random_programs(input int send_idle, input int recv_stall,
                                      input int count);
    int target;
    int r;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    target    = requests_sent + count;
    while (requests_sent < target) begin
      r = $urandom_range(99);
      if (r < 2) begin
        wait_all_results();
      end else if (r < 77) begin
        gen_program();
        repeat ($urandom_range(1, 3)) evaluate(random_states());
      end else if (r < 89) begin
        write_word(8'($urandom), 3'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        evaluate(random_states());
      end
    end
    wait_all_results();
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                  results_seen));
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_data_o.verdict !== oldest_result.verdict) begin
          report_mismatch($sformatf("result %0d verdict %0b, expected %0b", results_seen,
                                    out_data_o.verdict, oldest_result.verdict));
        end
        if (out_data_o.status !== oldest_result.status) begin
          report_mismatch($sformatf("result %0d status %0d, expected %0d", results_seen,
                                    out_data_o.status, oldest_result.status));
        end
      end
      results_seen++;
    end
  end

  initial begin
    #30_000_000;
    $display("prefix_boolean_shape_evaluator test failed");
    $finish;
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    fail_count    = 0;
    requests_sent = 0;
    results_seen  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_program_store();
    test_leaf_extremes();
    test_each_operation();
    test_zero_count();
    test_program_overrun();
    test_stack_overflow();
    wait_all_results();
    test_random_programs(0, 0, 110);
    test_random_programs(67, 0, 110);
    test_random_programs(0, 67, 110);
    test_random_programs(10, 10, 110);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("prefix_boolean_shape_evaluator test passed");
    end else begin
      $display("prefix_boolean_shape_evaluator test failed");
    end
    $finish;
  end

endmodule
